@@ src/pcct_pkg.sv @@
// Shared types and constants of the pulse-count code transmitter.
// No dependencies; imported by every module of the block.
package pcct_pkg;

    localparam int CFG_W      = 24;  // widest configuration register
    localparam int CFG_ADDR_W = 3;
    localparam int CODE_W     = 8;
    localparam int TEMP_W     = 13;  // signed 9.4 target
    localparam int DIV_W      = 9;   // magnitude of the quantizer dividend
    localparam int DIV_CNT_W  = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_GAP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_LOW   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_HIGH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_LOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_CODE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_TEMP   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TEMP   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_STEP  = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0]  RST_FRAME_GAP  = 24'd100000;
    localparam logic [CFG_W-1:0]  RST_SYNC_LOW   = 24'd3000;
    localparam logic [CFG_W-1:0]  RST_PULSE_HIGH = 24'd500;
    localparam logic [CFG_W-1:0]  RST_PULSE_LOW  = 24'd500;
    localparam logic [CODE_W-1:0] RST_OFF_CODE   = 8'd0;
    localparam logic [CODE_W-1:0] RST_MIN_TEMP   = 8'd40;
    localparam logic [CODE_W-1:0] RST_MAX_TEMP   = 8'd90;
    localparam logic [CODE_W-1:0] RST_TEMP_STEP  = 8'd5;

    // Step used when temp_step is zero
    localparam logic [CODE_W-1:0] DEFAULT_STEP   = 8'd5;

    // Input kind carried in tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic prep;      // round, clamp and load the divider
        logic div_step;  // one restoring divide step
        logic commit;    // update frame state and load the output register
    } t_cmd;

endpackage

@@ src/pcct_ctrl.sv @@
// Sequencer of the pulse-count code transmitter: handshakes and datapath commands.
// Depends on pcct_pkg.
module pcct_ctrl
    import pcct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output t_cmd o_cmd
);

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   w_accept;
    logic                   w_slot_free;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    assign w_accept    = s_axis_tvalid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == FUNC_APPLY) ? ST_PREP : ST_COMMIT;
                end
            end
            ST_PREP: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.capture = w_accept;
            end
            ST_PREP:   o_cmd.prep     = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_COMMIT: o_cmd.commit   = w_slot_free;
            default:   o_cmd          = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/pcct_dp.sv @@
// Datapath of the pulse-count code transmitter: registers, frame timer,
// command encoder with a serial divider, output register. Depends on pcct_pkg.
module pcct_dp
    import pcct_pkg::*;
#(
    parameter int TIME_WIDTH = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  t_cmd                  i_cmd,
    input  logic                  i_func,
    input  logic [IN_DATA_W-1:0]  i_data,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int CmpW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    // configuration
    logic [CFG_W-1:0]  r_frame_gap, r_sync_low, r_pulse_high, r_pulse_low;
    logic [CODE_W-1:0] r_off_code, r_min_temp, r_max_temp, r_temp_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_gap  <= RST_FRAME_GAP;
            r_sync_low   <= RST_SYNC_LOW;
            r_pulse_high <= RST_PULSE_HIGH;
            r_pulse_low  <= RST_PULSE_LOW;
            r_off_code   <= RST_OFF_CODE;
            r_min_temp   <= RST_MIN_TEMP;
            r_max_temp   <= RST_MAX_TEMP;
            r_temp_step  <= RST_TEMP_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_GAP:  r_frame_gap  <= i_cfg_wdata;
                CFG_SYNC_LOW:   r_sync_low   <= i_cfg_wdata;
                CFG_PULSE_HIGH: r_pulse_high <= i_cfg_wdata;
                CFG_PULSE_LOW:  r_pulse_low  <= i_cfg_wdata;
                CFG_OFF_CODE:   r_off_code   <= i_cfg_wdata[CODE_W-1:0];
                CFG_MIN_TEMP:   r_min_temp   <= i_cfg_wdata[CODE_W-1:0];
                CFG_MAX_TEMP:   r_max_temp   <= i_cfg_wdata[CODE_W-1:0];
                CFG_TEMP_STEP:  r_temp_step  <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // captured beat
    logic                     r_func, r_mode_off;
    logic signed [TEMP_W-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_mode_off <= i_data[0];
            r_target   <= $signed(i_data[TEMP_W:1]);
        end
    end

    // round half away from zero, clamp, form the signed dividend
    logic [CODE_W-1:0]        w_step;
    logic [TEMP_W:0]          w_v14, w_mag;
    logic [TEMP_W:0]          w_rnd_sum;
    logic [9:0]               w_rnd;
    logic signed [10:0]       w_t, w_t_min;
    logic [CODE_W-1:0]        w_tc;
    logic signed [9:0]        w_d;
    logic [DIV_W-1:0]         w_dmag;

    assign w_step    = (r_temp_step == '0) ? DEFAULT_STEP : r_temp_step;
    assign w_v14     = {r_target[TEMP_W-1], r_target};
    assign w_mag     = r_target[TEMP_W-1] ? ((TEMP_W+1)'(0) - w_v14) : w_v14;
    assign w_rnd_sum = w_mag + (TEMP_W+1)'(8);
    assign w_rnd     = w_rnd_sum[TEMP_W:4];

    always_comb begin
        w_t     = r_target[TEMP_W-1] ? -$signed({1'b0, w_rnd}) : $signed({1'b0, w_rnd});
        w_t_min = (w_t < $signed({3'b000, r_min_temp})) ? $signed({3'b000, r_min_temp}) : w_t;
        w_tc    = (w_t_min > $signed({3'b000, r_max_temp})) ? r_max_temp
                                                              : w_t_min[CODE_W-1:0];
        w_d     = $signed({2'b00, w_tc}) - $signed({2'b00, r_min_temp})
                  + $signed({3'b000, w_step[CODE_W-1:1]});
        w_dmag  = w_d[9] ? DIV_W'(-w_d) : w_d[DIV_W-1:0];
    end

    // restoring divider; only the remainder is needed
    logic                r_dsign;
    logic [DIV_W-1:0]    r_dmag, r_shift;
    logic [CODE_W-1:0]   r_rem;
    logic [DIV_W-1:0]    w_trial, w_trial_sub;
    logic [DIV_W-1:0]    w_mq;
    logic [CODE_W-1:0]   w_div_code;

    assign w_trial     = {r_rem, r_shift[DIV_W-1]};
    assign w_trial_sub = w_trial - {1'b0, w_step};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_dsign <= w_d[9];
            r_dmag  <= w_dmag;
            r_shift <= w_dmag;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[DIV_W-2:0], 1'b0};
            r_rem   <= (w_trial >= {1'b0, w_step}) ? w_trial_sub[CODE_W-1:0]
                                                   : w_trial[CODE_W-1:0];
        end
    end

    // quotient times step equals dividend minus remainder
    assign w_mq       = r_dmag - {1'b0, r_rem};
    assign w_div_code = r_dsign ? (r_min_temp - w_mq[CODE_W-1:0])
                                : (r_min_temp + w_mq[CODE_W-1:0]);

    // frame state
    t_phase                  r_phase, n_phase;
    logic                    r_line, n_line;
    logic [TIME_WIDTH-1:0]   r_elapsed, n_elapsed, w_elapsed_inc;
    logic [CODE_W-1:0]       r_pulses, n_pulses, w_pulses_dec;
    logic [CODE_W-1:0]       r_code, n_code;
    logic                    r_have_cmd, n_have_cmd;
    logic [CmpW-1:0]         w_el;
    logic [CODE_W-1:0]       w_sel_code;

    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_el          = CmpW'(w_elapsed_inc);
    assign w_pulses_dec  = (r_pulses != '0) ? r_pulses - 1'b1 : r_pulses;

    always_comb begin
        n_phase    = r_phase;
        n_line     = r_line;
        n_elapsed  = r_elapsed;
        n_pulses   = r_pulses;
        n_code     = r_code;
        n_have_cmd = r_have_cmd;
        if (r_func == FUNC_APPLY) begin
            n_code     = r_mode_off ? r_off_code : w_div_code;
            n_have_cmd = 1'b1;
        end else begin
            n_elapsed = w_elapsed_inc;
            case (r_phase)
                PH_IDLE: begin
                    if (w_el >= CmpW'(r_frame_gap)) begin
                        n_pulses  = r_have_cmd ? r_code : r_off_code;
                        n_phase   = PH_SYNC;
                        n_line    = 1'b0;
                        n_elapsed = '0;
                    end
                end
                PH_SYNC: begin
                    if (w_el >= CmpW'(r_sync_low)) begin
                        n_phase   = PH_HIGH;
                        n_line    = 1'b1;
                        n_elapsed = '0;
                    end
                end
                PH_HIGH: begin
                    if (w_el >= CmpW'(r_pulse_high)) begin
                        n_phase   = PH_LOW;
                        n_line    = 1'b0;
                        n_elapsed = '0;
                    end
                end
                PH_LOW: begin
                    if (w_el >= CmpW'(r_pulse_low)) begin
                        n_pulses  = w_pulses_dec;
                        n_elapsed = '0;
                        // a zero code still sends its one pulse
                        if (w_pulses_dec == '0) begin
                            n_phase = PH_IDLE;
                            n_line  = 1'b0;
                        end else begin
                            n_phase = PH_HIGH;
                            n_line  = 1'b1;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign w_sel_code = n_have_cmd ? n_code : r_off_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_line     <= 1'b0;
            r_elapsed  <= '0;
            r_pulses   <= '0;
            r_code     <= '0;
            r_have_cmd <= 1'b0;
        end else if (i_cmd.commit) begin
            r_phase    <= n_phase;
            r_line     <= n_line;
            r_elapsed  <= n_elapsed;
            r_pulses   <= n_pulses;
            r_code     <= n_code;
            r_have_cmd <= n_have_cmd;
        end
    end

    // output register: line_level, phase, pulse_code from bit 0 up
    logic [OUT_DATA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= {(OUT_DATA_W-11)'(0), w_sel_code, n_phase, n_line};
        end
    end

    assign o_data = r_out;

endmodule

@@ src/pulse_count_code_transmitter_core.sv @@
// Pulse-count code transmitter: frame timer and heater command encoder.
// Top level; instantiates pcct_ctrl and pcct_dp, depends on pcct_pkg.
//
// Usage:
//   The slave channel takes one beat per event: tuser = 0 is a one microsecond
//   tick that advances the frame timer, tuser = 1 applies a heater command
//   (mode_off and a signed 9.4 target in tdata) for the next frame. Each beat
//   yields one master beat with line level, frame phase and selected code.
//   A frame is an idle gap, a low sync phase and N high/low pulse pairs, N
//   being the selected code (zero still sends one pulse). Write registers
//   through i_cfg_we / i_cfg_addr / i_cfg_wdata only while no beat is in flight.
// Sequencing:
//   A tick beat goes from accept straight to commit; an apply beat passes
//   through prep, a 9-step restoring divide and commit. s_axis_tready is high
//   only while the sequencer is idle, so the next beat is taken only after the
//   previous one has committed and loaded the output register.
// Reset and stall:
//   Synchronous active-low reset restores register defaults, clears the frame
//   state and drops m_axis_tvalid. A stalled result holds in the output register;
//   the next beat is still processed, and its commit waits for the register.
module pulse_count_code_transmitter_core
    import pcct_pkg::*;
#(
    parameter int TIME_WIDTH = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] mode_off, [13:1] target_temp
    input  logic                  s_axis_tuser,  // [0] func
    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] line_level, [2:1] phase,
                                                 // [10:3] pulse_code
);

    t_cmd w_cmd;

    pcct_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    pcct_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_func      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_data      (m_axis_tdata)
    );

endmodule

@@ src/pcct_chk.sv @@
// Port-level checker of the pulse-count code transmitter, bound to the top level.
// Depends on pcct_pkg.
module pcct_chk
    import pcct_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // one beat at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    // reset drops the result channel
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // line is high exactly in the pulse-high phase
    a_line_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == PH_HIGH)))
        else $error("line level disagrees with phase");

endmodule

bind pulse_count_code_transmitter_core pcct_chk u_pcct_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
